[design/dpc_pkg.sv]
// shared types, constants and codes for the datagram pattern checker
package dpc_pkg;

	localparam int HDR_BYTES  = 24;
	localparam int HDR_IDX_W  = $clog2(HDR_BYTES);
	localparam int POS_W      = 17;
	localparam int LEN_W      = POS_W + 1;
	localparam int SEQ_W      = 64;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int WSUM_W     = 18;

	localparam logic [30:0] PAT_MULT = 31'd1315423911;
	localparam logic [8:0]  PAT_MOD  = 9'd251;
	localparam logic [7:0]  RES_LAST = 8'd250;
	localparam logic [3:0]  FOLD_MUL = 4'd5;

	// 256^k mod 251 for byte k of a 64-bit word, least significant first
	localparam logic [7:0] RES_WEIGHT [8] = '{
		8'd1, 8'd5, 8'd25, 8'd125, 8'd123, 8'd113, 8'd63, 8'd64
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAGIC    = 3'd0,
		REG_VERSION  = 3'd1,
		REG_SCENARIO = 3'd2,
		REG_NONCE    = 3'd3,
		REG_BODY_LEN = 3'd4
	} dpc_reg_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_LENGTH   = 2'd1,
		STAT_MISMATCH = 2'd2
	} dpc_status_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [15:0] version;
		logic [15:0] scenario;
		logic [63:0] nonce;
		logic [15:0] body_len;
	} dpc_cfg_t;

	typedef struct packed {
		logic       hdr_bad;
		logic       seed;
		logic       body;
		logic       last;
		logic       len_bad;
		logic [7:0] data;
	} dpc_ctrl_t;

	typedef struct packed {
		dpc_ctrl_t   ctrl;
		logic [63:0] val;
	} dpc_s1_t;

	typedef struct packed {
		dpc_ctrl_t          ctrl;
		logic [63:0]        val;
		logic [WSUM_W-1:0]  wsum;
	} dpc_s2_t;

	typedef struct packed {
		dpc_ctrl_t   ctrl;
		logic [63:0] val;
		logic [7:0]  res;
	} dpc_s3_t;

endpackage

[design/dpc_in_if.sv]
// byte request channel into the checker
interface dpc_in_if;
	logic                      valid;
	logic                      ready;
	logic [7:0]                data_byte;
	logic                      last_byte;
	logic [dpc_pkg::SEQ_W-1:0] expected_sequence;

	modport source(output valid, data_byte, last_byte, expected_sequence, input ready);
	modport sink(input valid, data_byte, last_byte, expected_sequence, output ready);
endinterface

[design/dpc_out_if.sv]
// verdict channel out of the checker
interface dpc_out_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [1:0] status;

	modport source(output valid, accepted, status, input ready);
	modport sink(input valid, accepted, status, output ready);
endinterface

[design/dpc_cfg_regs.sv]
// configuration register file with plain write port
module dpc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output dpc_pkg::dpc_cfg_t                 cfg
);
	import dpc_pkg::*;

	dpc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAGIC:    cfg_q.magic    <= cfg_wdata[31:0];
				REG_VERSION:  cfg_q.version  <= cfg_wdata[15:0];
				REG_SCENARIO: cfg_q.scenario <= cfg_wdata[15:0];
				REG_NONCE:    cfg_q.nonce    <= cfg_wdata;
				REG_BODY_LEN: cfg_q.body_len <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[design/dpc_front.sv]
// input stage: byte position, sequence latch, header compare and pattern seed
module dpc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  dpc_pkg::dpc_cfg_t cfg,
	dpc_in_if.sink            byte_chan,
	output dpc_pkg::dpc_s1_t  s1_item,
	output logic              s1_vld,
	input  logic              s1_ready
);
	import dpc_pkg::*;

	logic [POS_W-1:0]     pos_q;
	logic [SEQ_W-1:0]     seq_q;
	logic [62:0]          p_lo_q;
	logic [31:0]          p_hi_q;
	logic [63:0]          p_q;
	logic                 vld_s1;
	dpc_s1_t              item_s1;

	logic                 en1;
	logic                 take;
	logic                 is_hdr;
	logic [HDR_IDX_W-1:0] hdr_idx;
	logic [191:0]         hdr_vec;
	logic [7:0]           hdr_bytes [HDR_BYTES];
	logic [7:0]           hdr_exp;
	logic                 first;
	logic [LEN_W-1:0]     total;
	logic [LEN_W-1:0]     need;
	dpc_s1_t              item_d;

	assign en1            = !vld_s1 || s1_ready;
	assign byte_chan.ready = en1;
	assign take           = byte_chan.valid && en1;

	always_comb begin
		hdr_vec = {cfg.magic, cfg.version, cfg.scenario, cfg.nonce, seq_q};
		for (int k = 0; k < HDR_BYTES; k++) begin
			hdr_bytes[k] = hdr_vec[8*(HDR_BYTES-1-k) +: 8];
		end
		is_hdr  = pos_q < POS_W'(HDR_BYTES);
		hdr_idx = is_hdr ? pos_q[HDR_IDX_W-1:0] : '0;
		hdr_exp = hdr_bytes[hdr_idx];
		first   = (pos_q == '0);
		total   = {1'b0, pos_q} + LEN_W'(1);
		need    = LEN_W'(HDR_BYTES) + LEN_W'(cfg.body_len);

		item_d.ctrl.hdr_bad = (is_hdr && (byte_chan.data_byte != hdr_exp))
			|| (first && (byte_chan.expected_sequence == '0));
		item_d.ctrl.seed    = (pos_q == POS_W'(HDR_BYTES - 1));
		item_d.ctrl.body    = !is_hdr;
		item_d.ctrl.last    = byte_chan.last_byte;
		item_d.ctrl.len_bad = (total != need);
		item_d.ctrl.data    = byte_chan.data_byte;
		// start value of the body pattern, wraps at 64 bits
		item_d.val          = cfg.nonce + p_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seq_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= byte_chan.valid;
			end
			if (take) begin
				if (first) begin
					seq_q <= byte_chan.expected_sequence;
				end
				if (byte_chan.last_byte) begin
					pos_q <= '0;
				end else if (pos_q != '1) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	// sequence product is registered as partial products and then as their sum, from the latched sequence
	always_ff @(posedge clk) begin
		p_lo_q <= 63'(seq_q[31:0]) * 63'(PAT_MULT);
		p_hi_q <= seq_q[63:32] * 32'(PAT_MULT);
		p_q    <= 64'(p_lo_q) + {p_hi_q, 32'b0};
		if (en1) begin
			item_s1 <= item_d;
		end
	end

	assign s1_item = item_s1;
	assign s1_vld  = vld_s1;
endmodule

[design/dpc_residue.sv]
// two stages reducing the pattern start value modulo 251
module dpc_residue (
	input  logic             clk,
	input  logic             arst_n,
	input  dpc_pkg::dpc_s1_t s1_item,
	input  logic             s1_vld,
	output logic             s1_ready,
	output dpc_pkg::dpc_s3_t s3_item,
	output logic             s3_vld,
	input  logic             s3_ready
);
	import dpc_pkg::*;

	dpc_s2_t           item_s2;
	dpc_s3_t           item_s3;
	logic              vld_s2;
	logic              vld_s3;
	logic              en2;
	logic              en3;
	logic [WSUM_W-1:0] wsum;
	logic [12:0]       fold1;
	logic [8:0]        fold2;
	logic [7:0]        res;

	assign en3      = !vld_s3 || s3_ready;
	assign en2      = !vld_s2 || en3;
	assign s1_ready = en2;

	// 256 is 5 mod 251, so each byte gets its own small weight
	always_comb begin
		wsum = '0;
		for (int k = 0; k < 8; k++) begin
			wsum = wsum + WSUM_W'(s1_item.val[8*k +: 8]) * WSUM_W'(RES_WEIGHT[k]);
		end
	end

	always_comb begin
		fold1 = 13'(item_s2.wsum[WSUM_W-1:8]) * 13'(FOLD_MUL) + 13'(item_s2.wsum[7:0]);
		fold2 = 9'(fold1[12:8]) * 9'(FOLD_MUL) + 9'(fold1[7:0]);
		res   = (fold2 >= PAT_MOD) ? 8'(fold2 - PAT_MOD) : fold2[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en2) begin
				vld_s2 <= s1_vld;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			item_s2.ctrl <= s1_item.ctrl;
			item_s2.val  <= s1_item.val;
			item_s2.wsum <= wsum;
		end
		if (en3) begin
			item_s3.ctrl <= item_s2.ctrl;
			item_s3.val  <= item_s2.val;
			item_s3.res  <= res;
		end
	end

	assign s3_item = item_s3;
	assign s3_vld  = vld_s3;
endmodule

[design/dpc_verdict.sv]
// body pattern tracking, mismatch accumulation and verdict register
module dpc_verdict (
	input  logic             clk,
	input  logic             arst_n,
	input  dpc_pkg::dpc_s3_t s3_item,
	input  logic             s3_vld,
	output logic             s3_ready,
	dpc_out_if.source        verdict_chan
);
	import dpc_pkg::*;

	logic        mismatch_q;
	logic [7:0]  res_q;
	logic [63:0] pval_q;
	logic        out_vld_q;
	logic        accepted_q;
	dpc_status_t status_q;

	logic        out_free;
	logic        go;
	logic        body_bad;
	logic        mis_next;
	dpc_status_t status_d;

	assign out_free = !out_vld_q || verdict_chan.ready;
	assign s3_ready = !s3_item.ctrl.last || out_free;
	assign go       = s3_vld && s3_ready;
	assign body_bad = s3_item.ctrl.body && (s3_item.ctrl.data != res_q);
	assign mis_next = mismatch_q || s3_item.ctrl.hdr_bad || body_bad;

	always_comb begin
		if (s3_item.ctrl.len_bad) begin
			status_d = STAT_LENGTH;
		end else if (mis_next) begin
			status_d = STAT_MISMATCH;
		end else begin
			status_d = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_q <= 1'b0;
			res_q      <= '0;
			pval_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (go) begin
				mismatch_q <= s3_item.ctrl.last ? 1'b0 : mis_next;
				if (s3_item.ctrl.seed) begin
					res_q  <= s3_item.res;
					pval_q <= s3_item.val;
				end else if (s3_item.ctrl.body) begin
					pval_q <= pval_q + 64'd1;
					// residue restarts at zero after 250 and when the value wraps
					if ((&pval_q) || (res_q == RES_LAST)) begin
						res_q <= '0;
					end else begin
						res_q <= res_q + 8'd1;
					end
				end
			end
			if (go && s3_item.ctrl.last) begin
				out_vld_q <= 1'b1;
			end else if (verdict_chan.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && s3_item.ctrl.last) begin
			status_q   <= status_d;
			accepted_q <= (status_d == STAT_OK);
		end
	end

	assign verdict_chan.valid    = out_vld_q;
	assign verdict_chan.accepted = accepted_q;
	assign verdict_chan.status   = status_q;
endmodule

[design/datagram_pattern_checker.sv]
// top level of the datagram pattern checker
// Takes one datagram byte per request and can accept a request in every cycle, also while a
// verdict waits to be taken, unless another last byte is held at the verdict stage. A last
// byte passes the input register, two residue stages and the verdict register. The 24-byte
// header is compared against the configuration registers and the latched sequence as each
// byte arrives, the sequence is latched with the first byte, and its product with the pattern
// multiplier settles over the header bytes on one 32-bit multiplier pair. The body start
// residue is reduced in the two residue stages, so body bytes are checked in order at the
// verdict stage. Input ready follows the verdict channel through the stages in the same cycle.
module datagram_pattern_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	dpc_in_if.sink                         byte_chan,
	dpc_out_if.source                      verdict_chan
);
	import dpc_pkg::*;

	dpc_cfg_t cfg;
	dpc_s1_t  s1_item;
	logic     s1_vld;
	logic     s1_ready;
	dpc_s3_t  s3_item;
	logic     s3_vld;
	logic     s3_ready;

	dpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.byte_chan (byte_chan),
		.s1_item   (s1_item),
		.s1_vld    (s1_vld),
		.s1_ready  (s1_ready)
	);

	dpc_residue u_residue (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_item  (s1_item),
		.s1_vld   (s1_vld),
		.s1_ready (s1_ready),
		.s3_item  (s3_item),
		.s3_vld   (s3_vld),
		.s3_ready (s3_ready)
	);

	dpc_verdict u_verdict (
		.clk          (clk),
		.arst_n       (arst_n),
		.s3_item      (s3_item),
		.s3_vld       (s3_vld),
		.s3_ready     (s3_ready),
		.verdict_chan (verdict_chan)
	);

	// verdict flag agrees with the status code
	a_accept_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_chan.valid |-> (verdict_chan.accepted == (verdict_chan.status == STAT_OK)))
		else $error("accepted flag disagrees with status");

	// an empty input register never holds off a request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_vld |-> byte_chan.ready)
		else $error("input stalled with empty input register");

	// a new verdict only follows a last byte leaving the residue stages
	a_verdict_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(verdict_chan.valid) |-> $past(s3_vld && s3_ready && s3_item.ctrl.last))
		else $error("verdict without a last byte");
endmodule

[bench/datagram_pattern_checker_tb.sv]
// self-checking testbench for the datagram pattern checker
module datagram_pattern_checker_tb;
	import dpc_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int SETTLE       = 8;
	localparam int POS_SPAN     = 1 << POS_W;
	localparam longint LIMIT_TU = 64'd36_000_000;

	// verdict predictor and store of owed verdicts
	class verdict_scoreboard;
		typedef struct packed {
			logic        ok;
			dpc_status_t code;
		} verdict_t;

		dpc_cfg_t    regs;
		logic [16:0] pos;
		logic [63:0] seq_latch;
		logic [63:0] pat;
		bit          bad;
		verdict_t    owed_verdicts[$];
		int          errors;

		function new();
			regs      = '0;
			pos       = '0;
			seq_latch = '0;
			pat       = '0;
			bad       = 1'b0;
			errors    = 0;
		endfunction

		function void set_reg(dpc_reg_t r, logic [63:0] v);
			case (r)
				REG_MAGIC:    regs.magic    = v[31:0];
				REG_VERSION:  regs.version  = v[15:0];
				REG_SCENARIO: regs.scenario = v[15:0];
				REG_NONCE:    regs.nonce    = v;
				REG_BODY_LEN: regs.body_len = v[15:0];
				default: ;
			endcase
		endfunction

		// big-endian header byte p for the current registers and sequence s
		function logic [7:0] header_byte(int p, logic [63:0] s);
			logic [63:0] w;
			int          k;
			if (p < 4) begin
				w = 64'(regs.magic);
				k = 3 - p;
			end else if (p < 6) begin
				w = 64'(regs.version);
				k = 5 - p;
			end else if (p < 8) begin
				w = 64'(regs.scenario);
				k = 7 - p;
			end else if (p < 16) begin
				w = regs.nonce;
				k = 15 - p;
			end else begin
				w = s;
				k = 23 - p;
			end
			return w[8*k +: 8];
		endfunction

		// byte idx of a well-formed datagram carrying sequence s
		function logic [7:0] wire_byte(int idx, logic [63:0] s);
			logic [63:0] v;
			if (idx < HDR_BYTES)
				return header_byte(idx, s);
			v = regs.nonce + s * 64'(PAT_MULT) + 64'(idx - HDR_BYTES);
			return 8'(v % 64'(PAT_MOD));
		endfunction

		function int pending();
			return owed_verdicts.size();
		endfunction

		function void note_request(logic [7:0] b, logic last, logic [63:0] s);
			verdict_t v;
			int       total;
			if (pos == 0) begin
				seq_latch = s;
				if (s == 64'd0)
					bad = 1'b1;
			end
			if (pos < HDR_BYTES) begin
				if (b != header_byte(int'(pos), seq_latch))
					bad = 1'b1;
				if (pos == HDR_BYTES - 1)
					pat = regs.nonce + seq_latch * 64'(PAT_MULT);
			end else begin
				if (b != 8'(pat % 64'(PAT_MOD)))
					bad = 1'b1;
				pat = pat + 64'd1;
			end
			if (last) begin
				total = int'(pos) + 1;
				if (total != HDR_BYTES + int'(regs.body_len))
					v.code = STAT_LENGTH;
				else if (bad)
					v.code = STAT_MISMATCH;
				else
					v.code = STAT_OK;
				v.ok = (v.code == STAT_OK);
				owed_verdicts.push_back(v);
				pos = '0;
				bad = 1'b0;
			end else if (pos != 17'h1ffff) begin
				pos = pos + 17'd1;
			end
		endfunction

		function void check_verdict(logic acc, logic [1:0] st);
			verdict_t v;
			if (owed_verdicts.size() == 0) begin
				$display("%0t unexpected verdict: expected none, actual accepted %0b status %0d",
					$time, acc, st);
				errors++;
				return;
			end
			v = owed_verdicts.pop_front();
			if (acc !== v.ok) begin
				$display("%0t accepted mismatch: expected %0b, actual %0b", $time, v.ok, acc);
				errors++;
			end
			if (st !== v.code) begin
				$display("%0t status mismatch: expected %0d, actual %0d", $time, v.code, st);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	dpc_in_if  byte_chan();
	dpc_out_if verdict_chan();

	verdict_scoreboard sb;

	datagram_pattern_checker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.byte_chan    (byte_chan),
		.verdict_chan (verdict_chan)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#LIMIT_TU;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [63:0] pick_seq();
		logic [63:0] v;
		int          r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 64'd1;
		if (r == 1)
			return '1;
		v = {$urandom, $urandom};
		return (v == 64'd0) ? 64'd1 : v;
	endfunction

	function automatic logic [63:0] pick_word();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic dpc_cfg_t pick_config(int phase);
		dpc_cfg_t c;
		if (phase == 0) begin
			c = '0;
		end else if (phase == 1) begin
			c          = '1;
			c.body_len = 16'($urandom_range(1, 16));
		end else begin
			c.magic    = 32'(pick_word());
			c.version  = 16'(pick_word());
			c.scenario = 16'(pick_word());
			c.nonce    = pick_word();
			c.body_len = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 16));
		end
		return c;
	endfunction

	// lower valid between requests when g is nonzero; zero keeps the request stream back to back
	task automatic rest(input int g);
		if (g > 0) begin
			byte_chan.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic l, input logic [63:0] s);
		byte_chan.valid             <= 1'b1;
		byte_chan.data_byte         <= b;
		byte_chan.last_byte         <= l;
		byte_chan.expected_sequence <= s;
		do
			@(posedge clk);
		while (byte_chan.ready !== 1'b1);
		sb.note_request(b, l, s);
	endtask

	task automatic drain();
		rest(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic poke(input dpc_reg_t r, input logic [63:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_reg(r, v);
	endtask

	task automatic write_config(input dpc_cfg_t c);
		drain();
		repeat (SETTLE) @(posedge clk);
		poke(REG_MAGIC, 64'(c.magic));
		poke(REG_VERSION, 64'(c.version));
		poke(REG_SCENARIO, 64'(c.scenario));
		poke(REG_NONCE, c.nonce);
		poke(REG_BODY_LEN, 64'(c.body_len));
		cfg_wr_en <= 1'b0;
	endtask

	// bad_idx below zero leaves the datagram intact; past the position span the
	// byte pattern starts over, so a wrapping counter would see a fresh header
	task automatic send_datagram(input logic [63:0] seq, input int n, input int bad_idx,
			input logic [7:0] flip, input bit noise, input bit calm);
		int          wrap_i;
		logic [7:0]  b;
		logic [63:0] s;
		for (int i = 0; i < n; i++) begin
			wrap_i = i % POS_SPAN;
			b = noise ? 8'($urandom) : sb.wire_byte(wrap_i, seq);
			if (i == bad_idx)
				b = b ^ flip;
			s = (wrap_i == 0) ? seq : {$urandom, $urandom};
			push_byte(b, i == n - 1, s);
			if (!calm)
				rest(gap_len());
		end
	endtask

	initial begin : verdict_sink
		int hold;
		int calm;
		hold = 0;
		calm = 0;
		verdict_chan.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (verdict_chan.valid === 1'b1 && verdict_chan.ready === 1'b1)
				sb.check_verdict(verdict_chan.accepted, verdict_chan.status);
			if (calm > 0) begin
				calm--;
				verdict_chan.ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				verdict_chan.ready <= 1'b0;
			end else begin
				verdict_chan.ready <= 1'b1;
				if ($urandom_range(0, 49) == 0)
					calm = $urandom_range(20, 300);
				else
					hold = gap_len();
			end
		end
	end

	initial begin : stimulus
		dpc_cfg_t    c;
		logic [63:0] s;
		logic [7:0]  flip;
		int          n;
		int          full;
		int          r;
		int          bad_idx;
		int          phase;
		int          rand_bytes;
		int          rand_dgrams;
		bit          noise;
		bit          calm;

		sb = new();
		byte_chan.valid             = 1'b0;
		byte_chan.data_byte         = '0;
		byte_chan.last_byte         = 1'b0;
		byte_chan.expected_sequence = '0;
		cfg_wr_en                   = 1'b0;
		cfg_index                   = REG_MAGIC;
		cfg_wdata                   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nonce chosen so that sequence one starts the pattern three short of the 64-bit wrap
		c.magic    = 32'hA5C3_0F81;
		c.version  = 16'hFFFF;
		c.scenario = 16'h0000;
		c.nonce    = 64'd0 - 64'(PAT_MULT) - 64'd3;
		c.body_len = 16'd8;
		write_config(c);
		full = HDR_BYTES + 8;
		send_datagram(64'd1, full, -1, 8'h00, 1'b0, 1'b0);
		send_datagram(64'd0, full, -1, 8'h00, 1'b0, 1'b0);
		send_datagram(pick_seq(), 1, -1, 8'h00, 1'b0, 1'b1);
		send_datagram('1, full, -1, 8'h00, 1'b0, 1'b1);
		send_datagram(64'd1, full, 0, 8'h80, 1'b0, 1'b0);
		send_datagram(64'd1, full, HDR_BYTES + 4, 8'h01, 1'b0, 1'b0);

		phase       = 0;
		rand_bytes  = 0;
		rand_dgrams = 0;
		while (rand_bytes < 440) begin
			if (rand_dgrams % 4 == 0) begin
				c = pick_config(phase);
				phase++;
				write_config(c);
			end else if (rand_dgrams % 4 == 2) begin
				drain();
			end
			full    = HDR_BYTES + int'(c.body_len);
			n       = full;
			s       = pick_seq();
			bad_idx = -1;
			flip    = 8'h00;
			noise   = 1'b0;
			calm    = ($urandom_range(0, 3) == 0);
			r       = $urandom_range(0, 99);
			if (r < 15) begin
				bad_idx = $urandom_range(0, full - 1);
				flip    = 8'($urandom_range(1, 255));
			end else if (r < 25) begin
				do
					n = $urandom_range(1, full + 8);
				while (n == full);
			end else if (r < 30) begin
				s = '0;
			end else if (r < 45) begin
				noise = 1'b1;
				n     = $urandom_range(1, 40);
				s     = {$urandom, $urandom};
			end
			send_datagram(s, n, bad_idx, flip, noise, calm);
			rand_bytes += n;
			rand_dgrams++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
design/dpc_pkg.sv
design/dpc_in_if.sv
design/dpc_out_if.sv
design/dpc_cfg_regs.sv
design/dpc_front.sv
design/dpc_residue.sv
design/dpc_verdict.sv
design/datagram_pattern_checker.sv
bench/datagram_pattern_checker_tb.sv
